// File: rtl/iseu_pkg.sv
package iseu_pkg;

  // Default sizes
  localparam int NUM_REGS_DEF   = 13;
  localparam int MEM_DEPTH_DEF  = 256;
  localparam int PROG_DEPTH_DEF = 256;

  // Field widths
  localparam int KIND_W = 5;
  localparam int REG_W  = 4;
  localparam int BYTE_W = 8;

  // Span of an 8-bit byte address
  localparam int ADDR_SPAN = 1 << BYTE_W;

  // Stream payload widths
  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = 6;
  localparam int M_TDATA_W = 24;

  // Depth of the queue between front and back
  localparam int FIFO_DEPTH = 2;

  // Instruction kinds on the input stream
  localparam logic [KIND_W-1:0] KIND_LDR = 5'd0;
  localparam logic [KIND_W-1:0] KIND_STR = 5'd1;
  localparam logic [KIND_W-1:0] KIND_ADD = 5'd2;
  localparam logic [KIND_W-1:0] KIND_SUB = 5'd3;
  localparam logic [KIND_W-1:0] KIND_MOV = 5'd4;
  localparam logic [KIND_W-1:0] KIND_CMP = 5'd5;
  localparam logic [KIND_W-1:0] KIND_B   = 5'd6;
  localparam logic [KIND_W-1:0] KIND_BEQ = 5'd7;
  localparam logic [KIND_W-1:0] KIND_BNE = 5'd8;
  localparam logic [KIND_W-1:0] KIND_BLT = 5'd9;
  localparam logic [KIND_W-1:0] KIND_BGT = 5'd10;
  localparam logic [KIND_W-1:0] KIND_AND = 5'd11;
  localparam logic [KIND_W-1:0] KIND_ORR = 5'd12;
  localparam logic [KIND_W-1:0] KIND_EOR = 5'd13;
  localparam logic [KIND_W-1:0] KIND_MVN = 5'd14;
  localparam logic [KIND_W-1:0] KIND_LSL = 5'd15;
  localparam logic [KIND_W-1:0] KIND_LSR = 5'd16;

  // Compare flag encoding
  typedef enum logic [1:0] {
    FLAG_EQ = 2'd0,
    FLAG_LT = 2'd1,
    FLAG_GT = 2'd2
  } flag_t;

  // Internal operation after classification; illegal operands fold to OP_NOP
  typedef enum logic [4:0] {
    OP_NOP, OP_LDR, OP_STR, OP_MOV, OP_MVN, OP_CMP,
    OP_ADD, OP_SUB, OP_AND, OP_ORR, OP_EOR, OP_LSL, OP_LSR,
    OP_B, OP_BEQ, OP_BNE, OP_BLT, OP_BGT
  } op_t;

  // Classified instruction carried through the queue
  typedef struct packed {
    op_t               op;
    logic [REG_W-1:0]  rd;      // destination register
    logic [REG_W-1:0]  ra;      // register read on port A
    logic [REG_W-1:0]  rb;      // register read on port B
    logic              rb_ok;   // port B register exists
    logic              use_imm;
    logic [BYTE_W-1:0] imm;
    logic [BYTE_W-1:0] addr;    // already wrapped to the memory depth
    logic [BYTE_W-1:0] target;
  } dec_t;

endpackage

// File: rtl/teaching_isa_execute_unit.sv
// Execute unit for a small 8-bit load/store instruction set. Each input item
// is one decoded instruction; each produces exactly one result item. The unit
// takes one item per cycle and, with the output taken every cycle, delivers
// one result per cycle. The item is classified and written into a two-entry
// queue when it is accepted. Its operands are read into registers from the
// register file and data memory as it leaves the queue for the execute stage,
// and it is executed into the output register when that stage can advance.
// Results of earlier instructions are bypassed to the next one, so dependent
// instructions run back to back. Registers, data memory and the compare flag
// come out of reset as zero with no clearing pass: per-entry valid bits make
// unwritten entries read as zero.
module teaching_isa_execute_unit import iseu_pkg::*; #(
  parameter int NUM_REGS   = NUM_REGS_DEF,
  parameter int MEM_DEPTH  = MEM_DEPTH_DEF,
  parameter int PROG_DEPTH = PROG_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // dest_reg[3:0], first_reg[7:4], second_reg[11:8], second_immediate[19:12],
  // mem_address[27:20], jump_target[35:28], zero[39:36]
  input  logic [S_TDATA_W-1:0] s_tdata,
  // kind[4:0], second_is_immediate[5]
  input  logic [S_TUSER_W-1:0] s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // reg_written[0], written_value[8:1], branch_taken[9], next_target[17:10],
  // compare_state[19:18], zero[23:20]
  output logic [M_TDATA_W-1:0] m_tdata
);

  dec_t dec, head;
  logic full, head_valid, pop;

  assign s_tready = !full;

  // Front: classify the incoming instruction
  iseu_front #(
    .NUM_REGS   (NUM_REGS),
    .MEM_DEPTH  (MEM_DEPTH),
    .PROG_DEPTH (PROG_DEPTH)
  ) u_front (
    .kind                (s_tuser[4:0]),
    .dest_reg            (s_tdata[3:0]),
    .first_reg           (s_tdata[7:4]),
    .second_is_immediate (s_tuser[5]),
    .second_reg          (s_tdata[11:8]),
    .second_immediate    (s_tdata[19:12]),
    .mem_address         (s_tdata[27:20]),
    .jump_target         (s_tdata[35:28]),
    .dec                 (dec)
  );

  // Queue between front and back
  iseu_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (s_tvalid),
    .push_data  (dec),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head)
  );

  // Back: operand read, execute, result register
  iseu_back #(
    .NUM_REGS  (NUM_REGS),
    .MEM_DEPTH (MEM_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  // Output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A taken branch writes nothing
  a_branch_no_write: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[9]) |-> (!m_tdata[0] && m_tdata[8:1] == 8'h00))
    else $error("taken branch carries a write");

  // Target is reported only for a taken branch, and the flag is never illegal
  a_target_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[9] || m_tdata[17:10] == 8'h00) && m_tdata[19:18] != 2'd3))
    else $error("bad target or compare flag");

endmodule

// File: rtl/iseu_front.sv
module iseu_front import iseu_pkg::*; #(
  parameter int NUM_REGS   = NUM_REGS_DEF,
  parameter int MEM_DEPTH  = MEM_DEPTH_DEF,
  parameter int PROG_DEPTH = PROG_DEPTH_DEF
) (
  input  logic [KIND_W-1:0] kind,
  input  logic [REG_W-1:0]  dest_reg,
  input  logic [REG_W-1:0]  first_reg,
  input  logic              second_is_immediate,
  input  logic [REG_W-1:0]  second_reg,
  input  logic [BYTE_W-1:0] second_immediate,
  input  logic [BYTE_W-1:0] mem_address,
  input  logic [BYTE_W-1:0] jump_target,
  output dec_t              dec
);

  // Address wrap table, built at elaboration
  logic [BYTE_W-1:0] addr_wrap [ADDR_SPAN];

  for (genvar i = 0; i < ADDR_SPAN; i++) begin : g_wrap
    assign addr_wrap[i] = BYTE_W'(i % MEM_DEPTH);
  end

  logic rd_ok, rn_ok, rm_ok, tgt_ok;

  assign rd_ok  = 32'(dest_reg) < NUM_REGS;
  assign rn_ok  = 32'(first_reg) < NUM_REGS;
  assign rm_ok  = 32'(second_reg) < NUM_REGS;
  assign tgt_ok = 32'(jump_target) < PROG_DEPTH;

  // Classify the kind and fold illegal operands to a no-op
  always_comb begin
    dec.rd      = dest_reg;
    dec.ra      = first_reg;
    dec.rb      = second_reg;
    dec.rb_ok   = rm_ok;
    dec.use_imm = second_is_immediate;
    dec.imm     = second_immediate;
    dec.addr    = addr_wrap[mem_address];
    dec.target  = jump_target;
    dec.op      = OP_NOP;
    unique case (kind)
      KIND_LDR: dec.op = rd_ok ? OP_LDR : OP_NOP;
      KIND_STR: begin
        dec.op = rd_ok ? OP_STR : OP_NOP;
        dec.ra = dest_reg;
      end
      KIND_MOV: dec.op = rd_ok ? OP_MOV : OP_NOP;
      KIND_MVN: dec.op = rd_ok ? OP_MVN : OP_NOP;
      KIND_CMP: begin
        dec.op = rd_ok ? OP_CMP : OP_NOP;
        dec.ra = dest_reg;
      end
      KIND_ADD: dec.op = (rd_ok && rn_ok) ? OP_ADD : OP_NOP;
      KIND_SUB: dec.op = (rd_ok && rn_ok) ? OP_SUB : OP_NOP;
      KIND_AND: dec.op = (rd_ok && rn_ok) ? OP_AND : OP_NOP;
      KIND_ORR: dec.op = (rd_ok && rn_ok) ? OP_ORR : OP_NOP;
      KIND_EOR: dec.op = (rd_ok && rn_ok) ? OP_EOR : OP_NOP;
      KIND_LSL: dec.op = (rd_ok && rn_ok) ? OP_LSL : OP_NOP;
      KIND_LSR: dec.op = (rd_ok && rn_ok) ? OP_LSR : OP_NOP;
      KIND_B:   dec.op = tgt_ok ? OP_B : OP_NOP;
      KIND_BEQ: dec.op = tgt_ok ? OP_BEQ : OP_NOP;
      KIND_BNE: dec.op = tgt_ok ? OP_BNE : OP_NOP;
      KIND_BLT: dec.op = tgt_ok ? OP_BLT : OP_NOP;
      KIND_BGT: dec.op = tgt_ok ? OP_BGT : OP_NOP;
      default:  dec.op = OP_NOP;
    endcase
  end

endmodule

// File: rtl/iseu_fifo.sv
module iseu_fifo import iseu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  dec_t push_data,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output dec_t head_data
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  dec_t             slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full       = count == CNT_W'(FIFO_DEPTH);
  assign head_valid = count != '0;
  assign head_data  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push)
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)
        count <= count + 1'b1;
      else if (do_pop && !do_push)
        count <= count - 1'b1;
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (do_push)
      slots[wr_ptr] <= push_data;
  end

endmodule

// File: rtl/iseu_back.sv
module iseu_back import iseu_pkg::*; #(
  parameter int NUM_REGS  = NUM_REGS_DEF,
  parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  dec_t                 head_data,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int RIW       = $clog2(NUM_REGS);
  localparam int MEM_WORDS = (MEM_DEPTH < ADDR_SPAN) ? MEM_DEPTH : ADDR_SPAN;
  localparam int AW        = $clog2(MEM_WORDS);

  // Register file and data memory, with valid bits standing in for reset
  logic [BYTE_W-1:0] rf   [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld;
  logic [BYTE_W-1:0] dmem [MEM_WORDS];
  logic [MEM_WORDS-1:0] dm_vld;

  // Execute stage
  dec_t        x;
  logic        x_valid;
  logic        x_go;
  flag_t       flag;

  // Registered operand reads and their bypass from the stage ahead
  logic [BYTE_W-1:0] a_q, b_q, m_q;
  logic              a_v, b_v, m_v;
  logic              a_fw, b_fw, m_fw;
  logic [BYTE_W-1:0] a_fw_val, b_fw_val, m_fw_val;

  logic [BYTE_W-1:0] a_val, b_val, op2, mem_val, value;
  logic              wr, str, taken;
  flag_t             flag_next;

  assign x_go = x_valid && (!m_tvalid || m_tready);
  assign pop  = head_valid && (!x_valid || x_go);

  // Operand selection
  assign a_val   = a_fw ? a_fw_val : (a_v ? a_q : '0);
  assign b_val   = b_fw ? b_fw_val : (b_v ? b_q : '0);
  assign mem_val = m_fw ? m_fw_val : (m_v ? m_q : '0);
  assign op2     = x.use_imm ? x.imm : (x.rb_ok ? b_val : '0);

  // Execute
  always_comb begin
    wr        = 1'b0;
    str       = 1'b0;
    taken     = 1'b0;
    value     = '0;
    flag_next = flag;
    unique case (x.op)
      OP_LDR: begin wr = 1'b1; value = mem_val; end
      OP_STR: begin str = 1'b1; value = a_val; end
      OP_MOV: begin wr = 1'b1; value = op2; end
      OP_MVN: begin wr = 1'b1; value = ~op2; end
      OP_CMP: begin
        flag_next = (a_val == op2) ? FLAG_EQ : ((a_val < op2) ? FLAG_LT : FLAG_GT);
      end
      OP_ADD: begin wr = 1'b1; value = a_val + op2; end
      OP_SUB: begin wr = 1'b1; value = a_val - op2; end
      OP_AND: begin wr = 1'b1; value = a_val & op2; end
      OP_ORR: begin wr = 1'b1; value = a_val | op2; end
      OP_EOR: begin wr = 1'b1; value = a_val ^ op2; end
      OP_LSL: begin
        wr    = 1'b1;
        value = (op2[BYTE_W-1:3] != '0) ? '0 : (a_val << op2[2:0]);
      end
      OP_LSR: begin
        wr    = 1'b1;
        value = (op2[BYTE_W-1:3] != '0) ? '0 : (a_val >> op2[2:0]);
      end
      OP_B:    taken = 1'b1;
      OP_BEQ:  taken = flag == FLAG_EQ;
      OP_BNE:  taken = flag != FLAG_EQ;
      OP_BLT:  taken = flag == FLAG_LT;
      OP_BGT:  taken = flag == FLAG_GT;
      default: ;
    endcase
  end

  // Stage control, flag, valid bits, bypass and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid  <= 1'b0;
      m_tvalid <= 1'b0;
      flag     <= FLAG_EQ;
      rf_vld   <= '0;
      dm_vld   <= '0;
    end else begin
      if (pop)
        x_valid <= 1'b1;
      else if (x_go)
        x_valid <= 1'b0;
      if (x_go)
        m_tvalid <= 1'b1;
      else if (m_tready)
        m_tvalid <= 1'b0;
      if (x_go) begin
        flag <= flag_next;
        if (wr)
          rf_vld[x.rd[RIW-1:0]] <= 1'b1;
        if (str)
          dm_vld[x.addr[AW-1:0]] <= 1'b1;
      end
    end
  end

  // Payload of the execute stage and of the output register
  always_ff @(posedge clk) begin
    if (pop) begin
      x        <= head_data;
      a_v      <= rf_vld[head_data.ra[RIW-1:0]];
      b_v      <= rf_vld[head_data.rb[RIW-1:0]];
      m_v      <= dm_vld[head_data.addr[AW-1:0]];
      a_fw     <= x_go && wr && (x.rd == head_data.ra);
      b_fw     <= x_go && wr && (x.rd == head_data.rb);
      m_fw     <= x_go && str && (x.addr == head_data.addr);
      a_fw_val <= value;
      b_fw_val <= value;
      m_fw_val <= value;
    end
    if (x_go)
      m_tdata <= {4'b0000, flag_next, (taken ? x.target : 8'h00), taken, value, wr};
  end

  // Register file: two read ports, one write port
  always_ff @(posedge clk) begin
    if (x_go && wr)
      rf[x.rd[RIW-1:0]] <= value;
    if (pop) begin
      a_q <= rf[head_data.ra[RIW-1:0]];
      b_q <= rf[head_data.rb[RIW-1:0]];
    end
  end

  // Data memory: one read port, one write port
  always_ff @(posedge clk) begin
    if (x_go && str)
      dmem[x.addr[AW-1:0]] <= value;
    if (pop)
      m_q <= dmem[head_data.addr[AW-1:0]];
  end

endmodule
